@@ rtl/core/lcvc_pkg.sv @@
package lcvc_pkg;

  localparam int DIM_DEFAULT         = 4;
  localparam int COORD_WIDTH_DEFAULT = 16;
  localparam int NUM_COORDS          = 4;
  localparam int WEIGHT_W            = 16;
  localparam int OFFSET_W            = 32;
  localparam int COUNT_W             = 16;
  localparam int REG_INDEX_W         = 3;
  localparam int CFG_DATA_W          = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_WEIGHT_ZERO  = 3'd0,
    REG_WEIGHT_ONE   = 3'd1,
    REG_WEIGHT_TWO   = 3'd2,
    REG_WEIGHT_THREE = 3'd3,
    REG_OFFSET       = 3'd4,
    REG_LIMIT        = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic label_positive;
    logic last_point;
  } tag_t;

endpackage

@@ rtl/core/lcvc_cell.sv @@
module lcvc_cell #(
  parameter int COORD_WIDTH = lcvc_pkg::COORD_WIDTH_DEFAULT,
  parameter int SUM_W       = 40,
  parameter int INDEX       = 0
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           in_valid,
  output logic                                           in_ready,
  input  logic signed [SUM_W-1:0]                        in_sum,
  input  logic [lcvc_pkg::NUM_COORDS*COORD_WIDTH-1:0]    in_coords,
  input  lcvc_pkg::tag_t                                 in_tag,
  input  logic signed [lcvc_pkg::WEIGHT_W-1:0]           weight,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output logic signed [SUM_W-1:0]                        out_sum,
  output logic [lcvc_pkg::NUM_COORDS*COORD_WIDTH-1:0]    out_coords,
  output lcvc_pkg::tag_t                                 out_tag
);
  import lcvc_pkg::*;

  localparam int PROD_W = COORD_WIDTH + WEIGHT_W;

  logic signed [COORD_WIDTH-1:0] coord;
  logic signed [PROD_W-1:0]      product;

  assign in_ready = !out_valid || out_ready;
  assign coord    = in_coords[INDEX*COORD_WIDTH +: COORD_WIDTH];
  assign product  = PROD_W'(weight) * PROD_W'(coord);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_sum    <= in_sum + SUM_W'(product);
      out_coords <= in_coords;
      out_tag    <= in_tag;
    end
  end

endmodule

@@ rtl/core/lcvc_tally.sv @@
module lcvc_tally #(
  parameter int SUM_W = 40
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SUM_W-1:0]             in_sum,
  input  lcvc_pkg::tag_t                      in_tag,
  input  logic [lcvc_pkg::COUNT_W-1:0]        limit,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_wrong,
  output logic [lcvc_pkg::COUNT_W-1:0]        out_count,
  output logic                                out_within,
  output logic                                out_last
);
  import lcvc_pkg::*;

  logic [COUNT_W-1:0] running_wrong;
  logic [COUNT_W-1:0] count_next;
  logic               wrong;
  logic               fire;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  // A zero score is wrong for either label.
  always_comb begin
    wrong = (in_sum == '0) ||
            (in_tag.label_positive ? in_sum[SUM_W-1] : !in_sum[SUM_W-1]);
    if (wrong && running_wrong != COUNT_MAX) begin
      count_next = running_wrong + 1'b1;
    end else begin
      count_next = running_wrong;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      running_wrong <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (fire) begin
        running_wrong <= in_tag.last_point ? '0 : count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_wrong  <= wrong;
      out_count  <= count_next;
      out_within <= (count_next <= limit);
      out_last   <= in_tag.last_point;
    end
  end

endmodule

@@ rtl/core/linear_classifier_violation_count.sv @@
// Scores each labelled point against the configured hyperplane and keeps a
// saturating count of wrongly classified points per set. The block takes one
// item every clock cycle while the output is not held back; a row of
// DIM cells each adds one weight-times-coordinate product to the score it
// hands on, and a final stage updates the count and registers the result.
// Backpressure on the output stalls only the stages that are full.
module linear_classifier_violation_count #(
  parameter int DIM         = lcvc_pkg::DIM_DEFAULT,
  parameter int COORD_WIDTH = lcvc_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // coord_zero, coord_one, coord_two, coord_three
  input  logic [((lcvc_pkg::NUM_COORDS*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // label_positive
  input  logic [0:0]                            s_axis_tuser,
  input  logic                                  s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // wrong_count
  output logic [lcvc_pkg::COUNT_W-1:0]          m_axis_tdata,
  // point_wrong, within_limit
  output logic [1:0]                            m_axis_tuser,
  output logic                                  m_axis_tlast,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lcvc_pkg::REG_INDEX_W-1:0]      cfg_index,
  input  logic [lcvc_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import lcvc_pkg::*;

  localparam int PROD_W    = COORD_WIDTH + WEIGHT_W;
  localparam int WIDEST    = (PROD_W > OFFSET_W) ? PROD_W : OFFSET_W;
  localparam int SUM_W     = WIDEST + 3;
  localparam int COORDS_W  = NUM_COORDS * COORD_WIDTH;

  logic signed [WEIGHT_W-1:0] weight [NUM_COORDS];
  logic signed [OFFSET_W-1:0] offset_term;
  logic [COUNT_W-1:0]         violation_limit;

  logic                    chain_valid  [DIM+1];
  logic                    chain_ready  [DIM+1];
  logic signed [SUM_W-1:0] chain_sum    [DIM+1];
  logic [COORDS_W-1:0]     chain_coords [DIM+1];
  tag_t                    chain_tag    [DIM+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COORDS; i++) begin
        weight[i] <= '0;
      end
      offset_term     <= '0;
      violation_limit <= '0;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_WEIGHT_ZERO:  weight[0]       <= cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_ONE:   weight[1]       <= cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_TWO:   weight[2]       <= cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_THREE: weight[3]       <= cfg_data[WEIGHT_W-1:0];
        REG_OFFSET:       offset_term     <= cfg_data[OFFSET_W-1:0];
        REG_LIMIT:        violation_limit <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign chain_valid[0]  = s_axis_tvalid;
  assign s_axis_tready   = chain_ready[0];
  assign chain_sum[0]    = SUM_W'(offset_term);
  assign chain_coords[0] = s_axis_tdata[COORDS_W-1:0];
  assign chain_tag[0]    = '{label_positive: s_axis_tuser[0], last_point: s_axis_tlast};

  for (genvar g = 0; g < DIM; g++) begin : g_cell
    lcvc_cell #(
      .COORD_WIDTH (COORD_WIDTH),
      .SUM_W       (SUM_W),
      .INDEX       (g)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (chain_valid[g]),
      .in_ready   (chain_ready[g]),
      .in_sum     (chain_sum[g]),
      .in_coords  (chain_coords[g]),
      .in_tag     (chain_tag[g]),
      .weight     (weight[g]),
      .out_valid  (chain_valid[g+1]),
      .out_ready  (chain_ready[g+1]),
      .out_sum    (chain_sum[g+1]),
      .out_coords (chain_coords[g+1]),
      .out_tag    (chain_tag[g+1])
    );
  end

  lcvc_tally #(
    .SUM_W (SUM_W)
  ) u_tally (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (chain_valid[DIM]),
    .in_ready   (chain_ready[DIM]),
    .in_sum     (chain_sum[DIM]),
    .in_tag     (chain_tag[DIM]),
    .limit      (violation_limit),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_wrong  (m_axis_tuser[0]),
    .out_count  (m_axis_tdata),
    .out_within (m_axis_tuser[1]),
    .out_last   (m_axis_tlast)
  );

endmodule
